@@ hdl/stt_pkg.sv @@
// Shared types, codes and byte classification for the source text tokenizer.
package stt_pkg;

    localparam int TEXT_W     = 8;
    localparam int KIND_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CLASS_W    = 4;
    localparam int PUSH_MAX   = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    // Room kept free so an item in the input register and a new one both fit.
    localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 2 * PUSH_MAX;

    // token kinds
    localparam logic [KIND_W-1:0] K_IDENT      = 4'd0;
    localparam logic [KIND_W-1:0] K_NUMBER     = 4'd1;
    localparam logic [KIND_W-1:0] K_DOT        = 4'd2;
    localparam logic [KIND_W-1:0] K_DOTDOT     = 4'd3;
    localparam logic [KIND_W-1:0] K_COLON      = 4'd4;
    localparam logic [KIND_W-1:0] K_COLONCOLON = 4'd5;
    localparam logic [KIND_W-1:0] K_COMMA      = 4'd6;
    localparam logic [KIND_W-1:0] K_SYMBOL     = 4'd7;
    localparam logic [KIND_W-1:0] K_SYMPAIR    = 4'd8;
    localparam logic [KIND_W-1:0] K_SEMI       = 4'd9;
    localparam logic [KIND_W-1:0] K_EOF        = 4'd10;
    localparam logic [KIND_W-1:0] K_ERROR      = 4'd11;

    // run modes
    localparam logic [MODE_W-1:0] RM_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] RM_IDENT  = 2'd1;
    localparam logic [MODE_W-1:0] RM_NUMBER = 2'd2;
    localparam logic [MODE_W-1:0] RM_LONE   = 2'd3;

    // byte classes
    localparam logic [CLASS_W-1:0] C_SPACE  = 4'd0;
    localparam logic [CLASS_W-1:0] C_ALPHA  = 4'd1;
    localparam logic [CLASS_W-1:0] C_DIGIT  = 4'd2;
    localparam logic [CLASS_W-1:0] C_DOT    = 4'd3;
    localparam logic [CLASS_W-1:0] C_COLON  = 4'd4;
    localparam logic [CLASS_W-1:0] C_COMMA  = 4'd5;
    localparam logic [CLASS_W-1:0] C_SYMBOL = 4'd6;
    localparam logic [CLASS_W-1:0] C_SEMI   = 4'd7;
    localparam logic [CLASS_W-1:0] C_OTHER  = 4'd8;

    localparam logic [TEXT_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [TEXT_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;
    localparam logic [TEXT_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [TEXT_W-1:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TEXT_W-1:0] text;
        logic              first;
        logic              last;
        logic              run_last;
    } result_t;

    // results produced by one transaction, in order
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    // outcome of classifying a byte with nothing held
    typedef struct packed {
        logic              emit;
        result_t           res;
        logic              hold;
        logic [KIND_W-1:0] kind;
        logic [MODE_W-1:0] mode;
        logic              halt;
    } fresh_t;

    function automatic logic is_oper(logic [TEXT_W-1:0] c);
        return c == 8'h26 || c == 8'h2A || c == 8'h2B || c == 8'h2F || c == 8'h2D ||
               c == 8'h3F || c == 8'h7C || c == 8'h25 || c == 8'h3D || c == 8'h5E ||
               c == 8'h21;
    endfunction

    function automatic logic [CLASS_W-1:0] classify(logic [TEXT_W-1:0] c);
        logic [CLASS_W-1:0] cls;
        if (c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h0D)
            cls = C_SPACE;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER)
            cls = C_ALPHA;
        else if (c >= 8'h30 && c <= 8'h39)
            cls = C_DIGIT;
        else if (c == CH_DOT)
            cls = C_DOT;
        else if (c == CH_COLON)
            cls = C_COLON;
        else if (c == CH_COMMA)
            cls = C_COMMA;
        else if (c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D ||
                 c == 8'h5B || c == 8'h5D || is_oper(c))
            cls = C_SYMBOL;
        else if (c == CH_SEMI)
            cls = C_SEMI;
        else
            cls = C_OTHER;
        return cls;
    endfunction

    function automatic result_t mk_result(logic [KIND_W-1:0] kind, logic [TEXT_W-1:0] text,
                                          logic first, logic last);
        result_t r;
        r.kind     = kind;
        r.text     = text;
        r.first    = first;
        r.last     = last;
        r.run_last = 1'b0;
        return r;
    endfunction

    function automatic fresh_t fresh_step(logic [TEXT_W-1:0] c);
        fresh_t f;
        f = '0;
        unique case (classify(c))
            C_SPACE: ;
            C_ALPHA:
            begin
                f.hold = 1'b1; f.kind = K_IDENT; f.mode = RM_IDENT;
            end
            C_DIGIT:
            begin
                f.hold = 1'b1; f.kind = K_NUMBER; f.mode = RM_NUMBER;
            end
            C_DOT:
            begin
                f.hold = 1'b1; f.kind = K_DOT; f.mode = RM_LONE;
            end
            C_COLON:
            begin
                f.hold = 1'b1; f.kind = K_COLON; f.mode = RM_LONE;
            end
            C_SYMBOL:
            begin
                f.hold = 1'b1; f.kind = K_SYMBOL; f.mode = RM_LONE;
            end
            C_COMMA:
            begin
                f.emit = 1'b1; f.res = mk_result(K_COMMA, c, 1'b1, 1'b1);
            end
            C_SEMI:
            begin
                f.emit = 1'b1; f.res = mk_result(K_SEMI, c, 1'b1, 1'b1);
            end
            default:
            begin
                f.emit = 1'b1; f.halt = 1'b1; f.res = mk_result(K_ERROR, c, 1'b1, 1'b1);
            end
        endcase
        return f;
    endfunction

endpackage

@@ hdl/stt_if.sv @@
// Stream interfaces for source bytes in and token results out.
interface stt_in_if import stt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stt_out_if import stt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [TEXT_W-1:0] token_byte;
    logic              token_first;
    logic              token_last;
    logic              run_last;

    modport source (output valid, output token_kind, output token_byte, output token_first,
                    output token_last, output run_last, input ready);
    modport sink (input valid, input token_kind, input token_byte, input token_first,
                  input token_last, input run_last, output ready);
endinterface

@@ hdl/stt_lexer.sv @@
// Input register, held-byte state and per-transaction result generation.
module stt_lexer import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stt_in_if.sink      text_in,
    input  logic        space_ok,
    output push_t       push
);

    logic              in_vld_reg;
    logic [TEXT_W-1:0] in_byte_reg;
    logic              in_eot_reg;

    logic              held_valid_reg, held_valid_next;
    logic [TEXT_W-1:0] held_byte_reg, held_byte_next;
    logic [KIND_W-1:0] held_kind_reg, held_kind_next;
    logic              held_first_reg, held_first_next;
    logic [MODE_W-1:0] run_mode_reg, run_mode_next;
    logic              halted_reg, halted_next;

    fresh_t             fr;
    logic [CLASS_W-1:0] cls;
    push_t              p;

    assign text_in.ready = space_ok;
    assign fr  = fresh_step(in_byte_reg);
    assign cls = classify(in_byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= text_in.valid && text_in.ready;
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            in_byte_reg <= text_in.text_byte;
            in_eot_reg  <= text_in.end_of_text;
        end
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        held_kind_next  = held_kind_reg;
        held_first_next = held_first_reg;
        run_mode_next   = run_mode_reg;
        halted_next     = halted_reg;
        p = '0;

        if (in_vld_reg && !halted_reg)
        begin
            if (in_eot_reg)
            begin
                if (held_valid_reg)
                begin
                    p.r0  = mk_result(held_kind_reg, held_byte_reg, held_first_reg, 1'b1);
                    p.r1  = mk_result(K_EOF, '0, 1'b1, 1'b1);
                    p.cnt = 2'd2;
                end
                else
                begin
                    p.r0  = mk_result(K_EOF, '0, 1'b1, 1'b1);
                    p.cnt = 2'd1;
                end
                held_valid_next = 1'b0;
                held_byte_next  = '0;
                held_kind_next  = '0;
                held_first_next = 1'b0;
                run_mode_next   = RM_NONE;
            end
            else if (!held_valid_reg)
            begin
                if (fr.emit)
                begin
                    p.r0  = fr.res;
                    p.cnt = 2'd1;
                end
                if (fr.hold)
                begin
                    held_valid_next = 1'b1;
                    held_byte_next  = in_byte_reg;
                    held_kind_next  = fr.kind;
                    held_first_next = 1'b1;
                    run_mode_next   = fr.mode;
                end
                halted_next = fr.halt;
            end
            else if (run_mode_reg == RM_IDENT && (cls == C_ALPHA || cls == C_DIGIT))
            begin
                p.r0  = mk_result(held_kind_reg, held_byte_reg, held_first_reg, 1'b0);
                p.cnt = 2'd1;
                held_byte_next  = in_byte_reg;
                held_kind_next  = K_IDENT;
                held_first_next = 1'b0;
            end
            else if (run_mode_reg == RM_NUMBER && (cls == C_DIGIT || cls == C_DOT))
            begin
                p.r0  = mk_result(held_kind_reg, held_byte_reg, held_first_reg, 1'b0);
                p.cnt = 2'd1;
                held_byte_next  = in_byte_reg;
                held_kind_next  = K_NUMBER;
                held_first_next = 1'b0;
            end
            else if (run_mode_reg == RM_LONE &&
                     ((held_kind_reg == K_DOT && cls == C_DOT) ||
                      (held_kind_reg == K_COLON && cls == C_COLON) ||
                      (held_kind_reg == K_SYMBOL && is_oper(in_byte_reg))))
            begin
                // two-byte token: both bytes consumed
                p.r0 = mk_result(K_SYMPAIR, held_byte_reg, 1'b1, 1'b0);
                p.r1 = mk_result(K_SYMPAIR, in_byte_reg, 1'b0, 1'b1);
                if (held_kind_reg == K_DOT)
                begin
                    p.r0.kind = K_DOTDOT;
                    p.r1.kind = K_DOTDOT;
                end
                else if (held_kind_reg == K_COLON)
                begin
                    p.r0.kind = K_COLONCOLON;
                    p.r1.kind = K_COLONCOLON;
                end
                p.cnt = 2'd2;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
                held_kind_next  = '0;
                held_first_next = 1'b0;
                run_mode_next   = RM_NONE;
            end
            else
            begin
                // held token ends here; new byte starts afresh
                p.r0  = mk_result(held_kind_reg, held_byte_reg, held_first_reg, 1'b1);
                p.cnt = 2'd1;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
                held_kind_next  = '0;
                held_first_next = 1'b0;
                run_mode_next   = RM_NONE;
                if (fr.emit)
                begin
                    p.r1  = fr.res;
                    p.cnt = 2'd2;
                end
                if (fr.hold)
                begin
                    held_valid_next = 1'b1;
                    held_byte_next  = in_byte_reg;
                    held_kind_next  = fr.kind;
                    held_first_next = 1'b1;
                    run_mode_next   = fr.mode;
                end
                halted_next = fr.halt;
            end
        end

        if (p.cnt == 2'd1)
            p.r0.run_last = 1'b1;
        else if (p.cnt == 2'd2)
            p.r1.run_last = 1'b1;
    end

    assign push = p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            held_kind_reg  <= '0;
            held_first_reg <= 1'b0;
            run_mode_reg   <= RM_NONE;
            halted_reg     <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            held_kind_reg  <= held_kind_next;
            held_first_reg <= held_first_next;
            run_mode_reg   <= run_mode_next;
            halted_reg     <= halted_next;
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0 && (push.r0.kind == K_ERROR || push.r1.kind == K_ERROR))
        |=> halted_reg)
        else $error("error result without halt");

    a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> (push.r1.last && push.r1.run_last && !push.r0.run_last))
        else $error("second result of a transaction not marked last");

endmodule

@@ hdl/stt_result_fifo.sv @@
// Small result queue taking up to two results a cycle and giving one while the receiver is ready.
module stt_result_fifo import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic        space_ok,
    stt_out_if.source   token_out
);

    result_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wptr_reg, wptr_next;
    logic [FIFO_PTR_W-1:0]  rptr_reg, rptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   pop;
    result_t                head;

    assign head     = mem_reg[rptr_reg];
    assign pop      = token_out.valid && token_out.ready;
    assign space_ok = count_reg <= FIFO_CNT_W'(FIFO_ACCEPT_MAX);

    assign token_out.valid       = count_reg != '0;
    assign token_out.token_kind  = head.kind;
    assign token_out.token_byte  = head.text;
    assign token_out.token_first = head.first;
    assign token_out.token_last  = head.last;
    assign token_out.run_last    = head.run_last;

    always_comb
    begin
        wptr_next  = wptr_reg + FIFO_PTR_W'(push.cnt);
        rptr_next  = rptr_reg + FIFO_PTR_W'(pop);
        count_next = count_reg + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem_reg[wptr_reg + FIFO_PTR_W'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |=> token_out.valid)
        else $error("pushed result not offered");

endmodule

@@ hdl/source_text_tokenizer.sv @@
// Top level of the source text tokenizer: lexer stage plus result queue.
// An accepted byte is lexed from the input register; its results are queued, then offered.
// Throughput: one byte per cycle; one result leaves per cycle while the sink is ready;
//   a byte may cause up to two results, so the queue fill sets when input ready drops.
// Reset: rst_n asynchronous active low clears the held byte, run mode, halt flag and
//   the queue pointers; no clearing pass, the block accepts input right after reset.
module source_text_tokenizer import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stt_in_if.sink      text_in,
    stt_out_if.source   token_out
);

    // Results of one transaction, produced in the cycle after acceptance from the
    // registered byte and the held-byte state.
    push_t push;

    // Queue has room for the item in the input register plus a new one.
    logic  space_ok;

    stt_lexer u_lexer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .space_ok (space_ok),
        .push     (push)
    );

    // Eight-entry queue: accepts while at most four results wait, so the worst
    // case of two in-flight transactions of two results each always fits.
    stt_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .token_out (token_out)
    );

endmodule

@@ tb/source_text_tokenizer_tb.sv @@
// Self-checking testbench for the source text tokenizer: random text, lookahead predictor.
`timescale 1ns / 1ps

module source_text_tokenizer_tb;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 290;
    localparam int QUIET_TAIL    = 40;    // no idling while this few items remain
    localparam int DRAIN_EVERY   = 100;   // sender waits for an empty scoreboard this often
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_MAX     = 30;

    localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
    localparam logic [TEXT_W-1:0] CH_LF    = 8'h0A;
    localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;

    // one input transaction as queued for the driver
    typedef struct {
        logic [TEXT_W-1:0] text;
        logic              eot;
        logic              drain;   // hold off until every expected token byte is back
    } text_item_t;

    logic clk;
    logic rst_n;

    stt_in_if  text_in ();
    stt_out_if token_out ();

    source_text_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .token_out (token_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    text_item_t pending_text[$];
    result_t    expected_tokens[$];
    bit         byte_taken;
    bit         drain_next;
    int         send_gap;
    int         sink_stall;
    int         cycle_count;
    int         error_count;
    int         items_sent;
    int         tokens_checked;
    bit [11:0]  kinds_seen;

    // Lookahead predictor: one byte held back, same as the block's own state.
    bit                la_valid;
    logic [TEXT_W-1:0] la_byte;
    logic [KIND_W-1:0] la_kind;
    bit                la_first;
    logic [MODE_W-1:0] la_mode;
    bit                lexer_halted;

    // ------------------------------------------------------------------
    // Byte classes (ASCII only)
    // ------------------------------------------------------------------
    function automatic bit is_blank(logic [TEXT_W-1:0] c);
        return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
    endfunction

    function automatic bit is_letter(logic [TEXT_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [TEXT_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // bytes that may follow a symbol to form a pair
    function automatic bit is_operator(logic [TEXT_W-1:0] c);
        return c inside {"&", "*", "+", "/", "-", "?", "|", "%", "=", "^", "!"};
    endfunction

    function automatic bit is_bracket(logic [TEXT_W-1:0] c);
        return c inside {"(", ")", "{", "}", "[", "]"};
    endfunction

    function automatic bit is_known(logic [TEXT_W-1:0] c);
        return is_blank(c) || is_letter(c) || is_digit(c) || is_operator(c) ||
               is_bracket(c) || c inside {CH_UNDER, CH_DOT, CH_COLON, CH_COMMA, CH_SEMI};
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void lex_emit(logic [KIND_W-1:0] kind, logic [TEXT_W-1:0] b,
                                     logic first, logic last);
        result_t r;
        r.kind     = kind;
        r.text     = b;
        r.first    = first;
        r.last     = last;
        r.run_last = 1'b0;
        expected_tokens.push_back(r);
    endfunction

    function automatic void lex_hold(logic [TEXT_W-1:0] b, logic [KIND_W-1:0] kind,
                                     bit first, logic [MODE_W-1:0] mode);
        la_valid = 1'b1;
        la_byte  = b;
        la_kind  = kind;
        la_first = first;
        la_mode  = mode;
    endfunction

    function automatic void lex_clear();
        la_valid = 1'b0;
        la_byte  = '0;
        la_kind  = K_IDENT;
        la_first = 1'b0;
        la_mode  = RM_NONE;
    endfunction

    // held byte closes its token
    function automatic void lex_flush();
        if (la_valid)
            lex_emit(la_kind, la_byte, la_first, 1'b1);
        lex_clear();
    endfunction

    // byte seen with nothing held back
    function automatic void lex_fresh(logic [TEXT_W-1:0] c);
        if (is_blank(c))
            return;
        if (is_letter(c) || c == CH_UNDER)
            lex_hold(c, K_IDENT, 1'b1, RM_IDENT);
        else if (is_digit(c))
            lex_hold(c, K_NUMBER, 1'b1, RM_NUMBER);
        else if (c == CH_DOT)
            lex_hold(c, K_DOT, 1'b1, RM_LONE);
        else if (c == CH_COLON)
            lex_hold(c, K_COLON, 1'b1, RM_LONE);
        else if (c == CH_COMMA)
            lex_emit(K_COMMA, c, 1'b1, 1'b1);
        else if (is_bracket(c) || is_operator(c))
            lex_hold(c, K_SYMBOL, 1'b1, RM_LONE);
        else if (c == CH_SEMI)
            lex_emit(K_SEMI, c, 1'b1, 1'b1);
        else
        begin
            // unknown byte: error token, then silence until reset
            lexer_halted = 1'b1;
            lex_emit(K_ERROR, c, 1'b1, 1'b1);
        end
    endfunction

    // Expected token bytes for one accepted transaction.
    function automatic void lex_predict(logic [TEXT_W-1:0] c, logic eot);
        int      base;
        result_t tail;
        base = expected_tokens.size();
        if (lexer_halted)
            return;
        if (eot)
        begin
            lex_flush();
            lex_emit(K_EOF, '0, 1'b1, 1'b1);
        end
        else if (!la_valid)
            lex_fresh(c);
        else if (la_mode == RM_IDENT && (is_letter(c) || is_digit(c) || c == CH_UNDER))
        begin
            lex_emit(la_kind, la_byte, la_first, 1'b0);
            lex_hold(c, K_IDENT, 1'b0, RM_IDENT);
        end
        else if (la_mode == RM_NUMBER && (is_digit(c) || c == CH_DOT))
        begin
            lex_emit(la_kind, la_byte, la_first, 1'b0);
            lex_hold(c, K_NUMBER, 1'b0, RM_NUMBER);
        end
        else if (la_mode == RM_LONE && la_kind == K_DOT && c == CH_DOT)
        begin
            lex_emit(K_DOTDOT, la_byte, 1'b1, 1'b0);
            lex_emit(K_DOTDOT, c, 1'b0, 1'b1);
            lex_clear();
        end
        else if (la_mode == RM_LONE && la_kind == K_COLON && c == CH_COLON)
        begin
            lex_emit(K_COLONCOLON, la_byte, 1'b1, 1'b0);
            lex_emit(K_COLONCOLON, c, 1'b0, 1'b1);
            lex_clear();
        end
        else if (la_mode == RM_LONE && la_kind == K_SYMBOL && is_operator(c))
        begin
            lex_emit(K_SYMPAIR, la_byte, 1'b1, 1'b0);
            lex_emit(K_SYMPAIR, c, 1'b0, 1'b1);
            lex_clear();
        end
        else
        begin
            lex_flush();
            lex_fresh(c);
        end
        // the last byte this transaction produced carries run_last
        if (expected_tokens.size() > base)
        begin
            tail = expected_tokens.pop_back();
            tail.run_last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_token();
        result_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("token byte with nothing pending: kind %0d byte %02h",
                                      token_out.token_kind, token_out.token_byte));
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (want.kind <= K_ERROR)
            kinds_seen[want.kind] = 1'b1;
        if (token_out.token_kind !== want.kind)
            report_mismatch($sformatf("token #%0d kind %0d, want %0d",
                                      tokens_checked, token_out.token_kind, want.kind));
        if (token_out.token_byte !== want.text)
            report_mismatch($sformatf("token #%0d byte %02h, want %02h",
                                      tokens_checked, token_out.token_byte, want.text));
        if (token_out.token_first !== want.first)
            report_mismatch($sformatf("token #%0d first %b, want %b",
                                      tokens_checked, token_out.token_first, want.first));
        if (token_out.token_last !== want.last)
            report_mismatch($sformatf("token #%0d last %b, want %b",
                                      tokens_checked, token_out.token_last, want.last));
        if (token_out.run_last !== want.run_last)
            report_mismatch($sformatf("token #%0d run_last %b, want %b",
                                      tokens_checked, token_out.run_last, want.run_last));
    endtask

    // Idling stays off near the end and in the first quarter of each repeating window of the cycle count.
    function automatic bit idling_on();
        return pending_text.size() > QUIET_TAIL && (cycle_count % 1024) >= 256;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d token bytes still pending",
                         cycle_count, expected_tokens.size());
                $display("tb: failure");
                $finish;
            end
            else
            begin
                if (text_in.valid && text_in.ready)
                begin
                    lex_predict(text_in.text_byte, text_in.end_of_text);
                    items_sent++;
                    byte_taken = 1'b1;
                end
                if (token_out.valid && token_out.ready)
                    check_token();
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: source and sink change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        bit         next_valid;
        text_item_t it;
        if (rst_n)
        begin
            next_valid = text_in.valid;
            if (byte_taken)
            begin
                byte_taken = 1'b0;
                next_valid = 1'b0;
                if (idling_on() && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_text.size() > 0 &&
                         !(pending_text[0].drain && expected_tokens.size() != 0))
                begin
                    it = pending_text.pop_front();
                    next_valid = 1'b1;
                    text_in.text_byte   <= it.text;
                    text_in.end_of_text <= it.eot;
                end
            end
            text_in.valid <= next_valid;

            // receiver back-pressure in bursts
            if (sink_stall > 0)
            begin
                sink_stall--;
                token_out.ready <= 1'b0;
            end
            else
            begin
                token_out.ready <= 1'b1;
                if (idling_on() && $urandom_range(0, 5) == 0)
                    sink_stall = $urandom_range(1, 17);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(logic [TEXT_W-1:0] b);
        text_item_t it;
        it.text    = b;
        it.eot     = 1'b0;
        it.drain   = drain_next;
        drain_next = 1'b0;
        pending_text.push_back(it);
    endtask

    // end of text; the byte lane carries junk that must be ignored
    task automatic push_end(logic [TEXT_W-1:0] junk);
        text_item_t it;
        it.text    = junk;
        it.eot     = 1'b1;
        it.drain   = drain_next;
        drain_next = 1'b0;
        pending_text.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [TEXT_W-1:0] rand_word_char(bit lead);
        int r;
        r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return TEXT_W'("a" + r);
        else if (r < 52)
            return TEXT_W'("A" + (r - 26));
        else if (r == 52)
            return CH_UNDER;
        else
            return TEXT_W'("0" + (r - 53));
    endfunction

    function automatic logic [TEXT_W-1:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_LF;
            2: return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        string             opers;
        string             brackets;
        logic [TEXT_W-1:0] b;
        int                n;
        int                next_drain;

        opers    = "&*+/-?|%=^!";
        brackets = "(){}[]";

        clk             = 1'b0;
        rst_n           = 1'b0;
        text_in.valid       = 1'b0;
        text_in.text_byte   = '0;
        text_in.end_of_text = 1'b0;
        token_out.ready     = 1'b0;
        byte_taken  = 1'b0;
        drain_next  = 1'b0;
        send_gap    = 0;
        sink_stall  = 0;
        cycle_count = 0;
        error_count = 0;
        items_sent  = 0;
        tokens_checked = 0;
        kinds_seen  = '0;
        lex_clear();
        lexer_halted = 1'b0;

        // Directed text: ident with '_' and mixed case, number with a dot, "..", "::",
        // a symbol pair, a lone dot flushed by ':', a colon flushed by ';' (two
        // results from one byte), comma, symbols ended by tab, CR and LF, and
        // end of text both with a byte held and with nothing held.
        push_text("a_Z 9. ..::(&.:;,]");
        push_char(CH_TAB);
        push_char("{");
        push_char(CH_CR);
        push_char("}");
        push_char(CH_LF);
        push_char("z");
        push_end(8'hFF);
        push_end(8'h00);

        // Random part: mostly well-formed tokens with random content, some noise.
        drain_next = 1'b1;
        next_drain = pending_text.size() + DRAIN_EVERY;
        n = pending_text.size() + RANDOM_ITEMS;
        while (pending_text.size() < n)
        begin
            if (pending_text.size() >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
            case ($urandom_range(0, 15))
                0, 1, 2:
                begin
                    push_char(rand_word_char(1'b1));
                    repeat ($urandom_range(0, 6))
                        push_char(rand_word_char(1'b0));
                end
                3, 4:
                begin
                    push_char(TEXT_W'("0" + $urandom_range(0, 9)));
                    repeat ($urandom_range(0, 5))
                        push_char(($urandom_range(0, 3) == 0) ?
                                  CH_DOT : TEXT_W'("0" + $urandom_range(0, 9)));
                end
                5: push_text("..");
                6: push_text("::");
                7:
                begin
                    // symbol followed by an operator byte forms a pair
                    if ($urandom_range(0, 1))
                        push_char(brackets[$urandom_range(0, 5)]);
                    else
                        push_char(opers[$urandom_range(0, 10)]);
                    push_char(opers[$urandom_range(0, 10)]);
                end
                8: push_char(brackets[$urandom_range(0, 5)]);
                9: push_char($urandom_range(0, 1) ? CH_DOT : CH_COLON);
                10: push_char($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
                11: push_end(TEXT_W'($urandom_range(0, 255)));
                12:
                begin
                    // noise: any byte the lexer knows, in any order
                    repeat ($urandom_range(1, 3))
                    begin
                        do
                            b = TEXT_W'($urandom_range(0, 127));
                        while (!is_known(b));
                        push_char(b);
                    end
                end
                default: ;
            endcase
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2))
                push_char(rand_blank());
        end

        // Unknown byte with an identifier held: flush, error, then the block stays
        // silent for everything, end of text too.
        push_char("q");
        push_char(TEXT_W'($urandom_range(128, 255)));
        push_char("a");
        push_end(8'h5A);
        push_char(CH_SEMI);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_text.size() != 0 || text_in.valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d token bytes never arrived", expected_tokens.size()));

        $display("summary: %0d transactions sent, %0d token bytes checked, %0d of 12 kinds seen",
                 items_sent, tokens_checked, $countones(kinds_seen));
        $display("summary: halt after an unknown byte exercised, %0d mismatches", error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
